// ----- rtl/spwm_pkg.sv -----
// Shared constants for the sine-PWM sample generator: register map, field widths, sine ROM.
package spwm_pkg;

    localparam int DATA_W   = 16;
    localparam int AMP_W    = 15;
    localparam int ROM_W    = 8;
    localparam int ROM_LEN  = 361;
    localparam int ROM_AW   = 9;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_PWM_PERIOD  = 2'd0;
    localparam logic [1:0] REG_SAMPLES     = 2'd1;
    localparam logic [1:0] REG_THREE_PHASE = 2'd2;

    // command codes carried in tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    localparam logic [DATA_W-1:0] RST_PWM_PERIOD = 16'd1000;
    localparam logic [DATA_W-1:0] RST_SAMPLES    = 16'd1;
    localparam logic [DATA_W-1:0] RST_DAMP       = 16'd2;

    // phase offsets into the table
    localparam int PHASE_V_OFS = 120;
    localparam int PHASE_W_OFS = 240;
    localparam int SCALE_SHIFT = 7;

    typedef logic [DATA_W-1:0] t_word;

    localparam logic [ROM_W-1:0] SINE_ROM [0:ROM_LEN-1] = '{
        8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd74,
        8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
        8'd85, 8'd86, 8'd87, 8'd88, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95,
        8'd95, 8'd96, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
        8'd105, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd110, 8'd111, 8'd112,
        8'd113, 8'd113, 8'd114, 8'd115, 8'd115, 8'd116, 8'd117, 8'd117, 8'd118, 8'd118,
        8'd119, 8'd119, 8'd120, 8'd121, 8'd121, 8'd121, 8'd122, 8'd122, 8'd123, 8'd123,
        8'd124, 8'd124, 8'd124, 8'd125, 8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd126,
        8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd128,
        8'd128, 8'd128, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127,
        8'd127, 8'd126, 8'd126, 8'd126, 8'd126, 8'd125, 8'd125, 8'd125, 8'd124, 8'd124,
        8'd124, 8'd123, 8'd123, 8'd122, 8'd122, 8'd122, 8'd121, 8'd121, 8'd120, 8'd120,
        8'd119, 8'd118, 8'd118, 8'd117, 8'd117, 8'd116, 8'd115, 8'd115, 8'd114, 8'd113,
        8'd113, 8'd112, 8'd111, 8'd110, 8'd110, 8'd109, 8'd108, 8'd107, 8'd106, 8'd106,
        8'd105, 8'd104, 8'd103, 8'd102, 8'd101, 8'd100, 8'd99, 8'd98, 8'd97, 8'd97,
        8'd96, 8'd95, 8'd94, 8'd93, 8'd92, 8'd91, 8'd90, 8'd89, 8'd88, 8'd87,
        8'd85, 8'd84, 8'd83, 8'd82, 8'd81, 8'd80, 8'd79, 8'd78, 8'd77, 8'd76,
        8'd75, 8'd74, 8'd73, 8'd71, 8'd70, 8'd69, 8'd68, 8'd67, 8'd66, 8'd65,
        8'd64, 8'd62, 8'd61, 8'd60, 8'd59, 8'd58, 8'd57, 8'd56, 8'd55, 8'd54,
        8'd52, 8'd51, 8'd50, 8'd49, 8'd48, 8'd47, 8'd46, 8'd45, 8'd44, 8'd43,
        8'd42, 8'd41, 8'd40, 8'd39, 8'd38, 8'd37, 8'd36, 8'd35, 8'd34, 8'd33,
        8'd32, 8'd31, 8'd30, 8'd29, 8'd28, 8'd27, 8'd26, 8'd25, 8'd24, 8'd23,
        8'd22, 8'd22, 8'd21, 8'd20, 8'd19, 8'd18, 8'd18, 8'd17, 8'd16, 8'd15,
        8'd15, 8'd14, 8'd13, 8'd12, 8'd12, 8'd11, 8'd11, 8'd10, 8'd9, 8'd9,
        8'd8, 8'd8, 8'd7, 8'd7, 8'd6, 8'd6, 8'd5, 8'd5, 8'd4, 8'd4,
        8'd3, 8'd3, 8'd3, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd1, 8'd1,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd3, 8'd3,
        8'd3, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd7, 8'd7,
        8'd8, 8'd9, 8'd9, 8'd10, 8'd10, 8'd11, 8'd12, 8'd12, 8'd13, 8'd14,
        8'd14, 8'd15, 8'd16, 8'd17, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd21,
        8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd28, 8'd29, 8'd30,
        8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40,
        8'd41, 8'd42, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51,
        8'd52, 8'd53, 8'd54, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
        8'd64
    };

endpackage

// ----- rtl/spwm_three_phase_sample_generator.sv -----
// Three-phase sine-PWM compare value generator with a bit-serial index divider.
//
//  channel   dir  handshake                   payload
//  s (cmd)   in   i_s_tvalid / o_s_tready     tuser = cmd, tdata[14:0] = amplitude
//  m (duty)  out  o_m_tvalid / i_m_tready     tdata = duty_u, duty_v, duty_w; tlast = last
//  apb cfg   in   i_psel, i_penable, i_pwrite pwm_period @0, samples_per_cycle @4, three_phase @8
//
// Start items and sample requests past the end of the period are taken in the idle state
// and produce no output. A sample runs through divide, then ROM, multiply and accumulate
// once per phase (only U in single-phase mode), then output; the restoring divider yields
// one quotient bit a cycle. A result waits in the output register; the next item may be taken
// meanwhile, and its result holds in the last step until the output register frees.
// Reset is synchronous, active low, and restores registers and period state.
module spwm_three_phase_sample_generator
    import spwm_pkg::*;
#(
    parameter int TABLE_SIZE = 360
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // stream in
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [15:0]          i_s_tdata,   // [14:0] amplitude, [15] zero
    input  logic                 i_s_tuser,   // [0] cmd
    // stream out
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,   // [15:0] duty_u, [31:16] duty_v, [47:32] duty_w
    output logic                 o_m_tlast,
    // configuration
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [PADDR_W-1:0]   i_paddr,
    input  logic [PDATA_W-1:0]   i_pwdata,
    output logic [PDATA_W-1:0]   o_prdata,
    output logic                 o_pready
);

    localparam int TSW  = $clog2(TABLE_SIZE);
    localparam int PW   = DATA_W + TSW;
    localparam int CW   = $clog2(PW);
    localparam int MW   = ROM_W + DATA_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ROM  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    logic [2:0]        r_state;
    t_word             r_pwm_period;
    t_word             r_samples;
    logic              r_three_phase;
    t_word             r_idx;
    t_word             r_damp;
    t_word             r_offs;
    t_word             r_cnt;
    logic [PW-1:0]     r_quo;
    t_word             r_rem;
    logic [CW-1:0]     r_bit;
    logic [TSW-1:0]    r_pos;
    logic [1:0]        r_ph;
    logic [ROM_W-1:0]  r_rom;
    logic [MW-1:0]     r_scl;
    t_word             r_du;
    t_word             r_dv;
    t_word             r_dw;
    logic              r_m_valid;
    logic [47:0]       r_m_data;
    logic              r_m_last;

    logic              w_s_xfer;
    logic              w_cfg_wr;
    logic [1:0]        w_reg;
    logic [AMP_W-1:0]  w_amp;
    t_word             w_cnt;
    logic [DATA_W:0]   w_rem_sh;
    logic              w_ge;
    logic [DATA_W:0]   w_rem_diff;
    logic [TSW:0]      w_sum;
    logic [TSW:0]      w_wrap;
    logic [ROM_AW-1:0] w_rom_addr;
    t_word             w_duty;
    t_word             w_idx_nx;
    logic              w_out_free;

    assign o_pready   = 1'b1;
    assign w_reg      = i_paddr[3:2];
    assign w_cfg_wr   = i_psel && i_penable && i_pwrite;

    always_comb begin
        o_prdata = '0;
        case (w_reg)
            REG_PWM_PERIOD:  o_prdata = {16'd0, r_pwm_period};
            REG_SAMPLES:     o_prdata = {16'd0, r_samples};
            REG_THREE_PHASE: o_prdata = {31'd0, r_three_phase};
            default:         o_prdata = '0;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_amp      = i_s_tdata[AMP_W-1:0];
    assign w_cnt      = (r_samples == '0) ? RST_SAMPLES : r_samples;

    // restoring division step: one quotient bit per cycle
    assign w_rem_sh   = {r_rem, r_quo[PW-1]};
    assign w_ge       = (w_rem_sh >= {1'b0, r_cnt});
    assign w_rem_diff = w_rem_sh - {1'b0, r_cnt};

    // phase position, wrapped once into the table
    always_comb begin
        case (r_ph)
            PH_V:    w_sum = {1'b0, r_pos} + (TSW+1)'(PHASE_V_OFS);
            PH_W:    w_sum = {1'b0, r_pos} + (TSW+1)'(PHASE_W_OFS);
            default: w_sum = {1'b0, r_pos};
        endcase
        w_wrap = (w_sum >= (TSW+1)'(TABLE_SIZE)) ? (w_sum - (TSW+1)'(TABLE_SIZE)) : w_sum;
    end
    assign w_rom_addr = ROM_AW'(w_wrap);

    assign w_duty     = r_offs + r_scl[SCALE_SHIFT+DATA_W-1:SCALE_SHIFT];
    assign w_idx_nx   = r_idx + 16'd1;
    assign w_out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pwm_period  <= RST_PWM_PERIOD;
            r_samples     <= RST_SAMPLES;
            r_three_phase <= 1'b0;
            r_idx         <= '0;
            r_damp        <= RST_DAMP;
            r_offs        <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_reg)
                    REG_PWM_PERIOD:  r_pwm_period  <= i_pwdata[DATA_W-1:0];
                    REG_SAMPLES:     r_samples     <= i_pwdata[DATA_W-1:0];
                    REG_THREE_PHASE: r_three_phase <= i_pwdata[0];
                    default: ;
                endcase
            end

            // S_OUT sets the valid itself whenever the output register frees
            if (r_m_valid && i_m_tready && r_state != S_OUT) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_s_xfer) begin
                        if (i_s_tuser == CMD_START) begin
                            r_damp <= {w_amp, 1'b0};
                            r_offs <= (r_pwm_period >> 1) - {1'b0, w_amp};
                            r_idx  <= '0;
                        end else if (r_idx < w_cnt) begin
                            r_cnt   <= w_cnt;
                            r_quo   <= PW'(r_idx) * PW'(TABLE_SIZE);
                            r_rem   <= '0;
                            r_bit   <= CW'(PW - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[PW-2:0], w_ge};
                    r_rem <= w_ge ? w_rem_diff[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= S_ROM;
                    end
                end
                S_ROM: begin
                    if (r_ph == PH_U) begin
                        r_pos <= r_quo[TSW-1:0];
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_scl   <= MW'(r_rom) * MW'(r_damp);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    case (r_ph)
                        PH_V:    r_dv <= w_duty;
                        PH_W:    r_dw <= w_duty;
                        default: r_du <= w_duty;
                    endcase
                    if (r_ph == PH_W || !r_three_phase) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ROM;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {r_three_phase ? r_dw : 16'd0,
                                      r_three_phase ? r_dv : 16'd0, r_du};
                        r_m_last  <= (w_idx_nx == r_cnt);
                        r_idx     <= w_idx_nx;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // phase counter and registered ROM read
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            r_ph <= PH_U;
        end else if (r_state == S_ACC) begin
            r_ph <= r_ph + 2'd1;
        end
        if (r_state == S_ROM) begin
            if (r_ph == PH_U) begin
                r_rom <= SINE_ROM[ROM_AW'(r_quo[TSW-1:0])];
            end else begin
                r_rom <= SINE_ROM[w_rom_addr];
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule
